/* sv/elf_stream_loader_assert.svh */
// Assertion macros for the ELF stream loader.
`ifndef ELF_STREAM_LOADER_ASSERT_SVH
`define ELF_STREAM_LOADER_ASSERT_SVH
`ifndef SYNTH
`define ESL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ESL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ESL_ASSERT(label, prop, msg)
`define ESL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* sv/esl_pkg.sv */
// Shared types and constants of the ELF stream loader.
package esl_pkg;
   localparam logic [31:0] ELF_MAGIC = 32'h464C457F;
   localparam int unsigned EHDR_BYTES = 52;
   localparam int unsigned PHDR_REC_BYTES = 32;
   localparam logic [31:0] PT_LOAD = 32'd1;
   localparam int unsigned RD_ADDR_W = 10;

   // Program header field offsets inside one record.
   localparam logic [4:0] OFF_TYPE = 5'd0;
   localparam logic [4:0] OFF_OFFSET = 5'd4;
   localparam logic [4:0] OFF_PADDR = 5'd12;
   localparam logic [4:0] OFF_FILESZ = 5'd16;
   localparam logic [4:0] OFF_MEMSZ = 5'd20;

   typedef struct packed {
      logic                 start;
      logic [RD_ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] data;
   } rd_rsp_type;
endpackage

/* sv/elf_stream_loader.sv */
// ELF32 stream loader: consumes an image byte by byte and issues memory writes.
// Usage: the req channel carries one item per transfer. req_tuser is the kind
// (0 = received byte, 1 = tick) and req_tdata[7:0] the byte. Every accepted item
// yields exactly one rsp transfer holding a write (byte write while loading, a
// zero word during fill) or nothing, plus the done flag with bad_magic and the
// entry point. A plain byte passes through the execute and result states before
// its response transfer. The byte that ends the program headers (if the magic
// matches), or a copied byte that ends a segment, also scans the stored program
// headers through the shared word reader: a loadable record needs five word
// reads (type, file size, offset, address, memory size). A tick in the fill
// phase loads the next zero region as needed and emits one zero word or, when
// none is left, the done result.
// The block takes one item at a time: req_tready is high only while it is idle
// and the response register is empty, so a stalled receiver holds off input.
// Reset returns the loader to the file header phase and empties the response.
// After done, every further item answers with the same done result.
module elf_stream_loader #(
   parameter int PH_STORE_BYTES = 128,
   parameter int ZERO_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [0] wr_valid, [32:1] wr_addr, [64:33] wr_data,
                                     // [65] done_res, [66] bad_magic, [98:67] entry_point
   output logic         rsp_tuser    // [0] wr_is_word
);
   `include "elf_stream_loader_assert.svh"

   localparam int AW = $clog2(PH_STORE_BYTES);
   localparam int NREC = PH_STORE_BYTES / 32;
   localparam int IW = $clog2(NREC + 1);
   localparam int ZCW = $clog2(ZERO_SLOTS + 1);
   localparam int ZIW = (ZERO_SLOTS > 1) ? $clog2(ZERO_SLOTS) : 1;

   typedef enum logic [2:0] {
      PH_HDR, PH_PROG, PH_LOAD, PH_ZERO, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_HDR_MUL, S_HDR_CHK, S_FINISH, S_NEXT, S_RD_TYPE,
      S_RD_FSZ, S_RD_OFF, S_RD_PADDR, S_RD_MSZ, S_ZFETCH, S_ZEMIT, S_RESULT
   } state_type;

   state_type   state_ff;
   phase_type   phase_ff;
   logic        func_ff;
   logic [7:0]  byte_ff;
   logic [31:0] pos_ff;
   logic [31:0] magic_ff;
   logic [31:0] entry_ff;
   logic [15:0] pes_ff;
   logic [15:0] pcnt_ff;
   logic [31:0] total_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] rec_ff;
   logic [31:0] skip_ff;
   logic [31:0] copy_ff;
   logic [31:0] dest_ff;
   logic [31:0] fsz_ff;
   logic [31:0] paddr_ff;
   logic [31:0] pend_addr_ff;
   logic [29:0] pend_words_ff;
   logic [31:0] zaddr_ff [ZERO_SLOTS];
   logic [29:0] zwords_ff [ZERO_SLOTS];
   logic [ZCW-1:0] zrc_ff;
   logic [ZCW-1:0] zri_ff;
   logic [31:0] zleft_ff;
   logic        bad_ff;
   logic        wv_ff, ww_ff;
   logic [31:0] wa_ff, wd_ff;
   logic        rsp_valid_ff;
   logic        out_wv_ff, out_ww_ff, out_done_ff, out_bad_ff;
   logic [31:0] out_wa_ff, out_wd_ff, out_entry_ff;
   esl_pkg::rd_req_type rd_req_ff;
   esl_pkg::rd_rsp_type rd_rsp;

   logic          req_fire;
   logic [31:0]   prog_idx;
   logic          st_wr_en;
   logic [AW-1:0] rec_base;
   logic [31:0]   mem_diff;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire = req_tvalid && req_tready;
   assign prog_idx = pos_ff - 32'(esl_pkg::EHDR_BYTES);
   assign st_wr_en = (state_ff == S_EXEC) && !func_ff && (phase_ff == PH_PROG) &&
                     (prog_idx < 32'(PH_STORE_BYTES));
   assign rec_base = AW'({rec_ff, 5'd0});
   assign mem_diff = rd_rsp.data - fsz_ff;

   esl_word_reader #(
      .PH_STORE_BYTES(PH_STORE_BYTES)
   ) u_reader (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (st_wr_en),
      .wr_idx (prog_idx[AW-1:0]),
      .wr_byte(byte_ff),
      .rd_req (rd_req_ff),
      .rd_rsp (rd_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HDR;
         pos_ff <= 32'd0;
         idx_ff <= '0;
         skip_ff <= 32'd0;
         copy_ff <= 32'd0;
         dest_ff <= 32'd0;
         zrc_ff <= '0;
         zri_ff <= '0;
         zleft_ff <= 32'd0;
         bad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_req_ff <= '0;
      end else begin
         rd_req_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  func_ff <= req_tuser;
                  byte_ff <= req_tdata;
                  wv_ff <= 1'b0;
                  ww_ff <= 1'b0;
                  wa_ff <= 32'd0;
                  wd_ff <= 32'd0;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_RESULT;
               if (!func_ff) begin
                  case (phase_ff)
                     PH_HDR: begin
                        if (pos_ff < 32'd4) begin
                           magic_ff[{pos_ff[1:0], 3'b000} +: 8] <= byte_ff;
                        end else if (pos_ff >= 32'd24 && pos_ff < 32'd28) begin
                           entry_ff[{pos_ff[1:0], 3'b000} +: 8] <= byte_ff;
                        end else if (pos_ff == 32'd42) begin
                           pes_ff[7:0] <= byte_ff;
                        end else if (pos_ff == 32'd43) begin
                           pes_ff[15:8] <= byte_ff;
                        end else if (pos_ff == 32'd44) begin
                           pcnt_ff[7:0] <= byte_ff;
                        end else if (pos_ff == 32'd45) begin
                           pcnt_ff[15:8] <= byte_ff;
                        end
                        pos_ff <= pos_ff + 32'd1;
                        if (pos_ff == 32'(esl_pkg::EHDR_BYTES - 1)) begin
                           state_ff <= S_HDR_MUL;
                        end
                     end
                     PH_PROG: begin
                        pos_ff <= pos_ff + 32'd1;
                        if (pos_ff - 32'(esl_pkg::EHDR_BYTES - 1) == total_ff) begin
                           state_ff <= S_FINISH;
                        end
                     end
                     PH_LOAD: begin
                        pos_ff <= pos_ff + 32'd1;
                        if (skip_ff != 32'd0) begin
                           skip_ff <= skip_ff - 32'd1;
                        end else begin
                           wv_ff <= 1'b1;
                           wa_ff <= dest_ff;
                           wd_ff <= {24'd0, byte_ff};
                           dest_ff <= dest_ff + 32'd1;
                           copy_ff <= copy_ff - 32'd1;
                           if (copy_ff == 32'd1) begin
                              // Segment complete: record its zero-fill region.
                              zaddr_ff[zrc_ff[ZIW-1:0]] <= pend_addr_ff;
                              zwords_ff[zrc_ff[ZIW-1:0]] <= pend_words_ff;
                              zrc_ff <= zrc_ff + ZCW'(1);
                              state_ff <= S_NEXT;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (phase_ff == PH_ZERO) begin
                  state_ff <= S_ZFETCH;
               end
            end
            S_HDR_MUL: begin
               total_ff <= {16'd0, pes_ff} * {16'd0, pcnt_ff};
               state_ff <= S_HDR_CHK;
            end
            S_HDR_CHK: begin
               if (total_ff == 32'd0) begin
                  state_ff <= S_FINISH;
               end else begin
                  phase_ff <= PH_PROG;
                  state_ff <= S_RESULT;
               end
            end
            S_FINISH: begin
               if (magic_ff != esl_pkg::ELF_MAGIC) begin
                  bad_ff <= 1'b1;
                  phase_ff <= PH_DONE;
                  state_ff <= S_RESULT;
               end else begin
                  idx_ff <= '0;
                  zrc_ff <= '0;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if ({{(16 - IW){1'b0}}, idx_ff} < pcnt_ff && idx_ff < IW'(NREC) &&
                   zrc_ff < ZCW'(ZERO_SLOTS)) begin
                  rec_ff <= idx_ff;
                  idx_ff <= idx_ff + IW'(1);
                  rd_req_ff.start <= 1'b1;
                  rd_req_ff.addr <= esl_pkg::RD_ADDR_W'(AW'({idx_ff, 5'd0}));
                  state_ff <= S_RD_TYPE;
               end else begin
                  phase_ff <= PH_ZERO;
                  zri_ff <= '0;
                  zleft_ff <= 32'd0;
                  state_ff <= S_RESULT;
               end
            end
            S_RD_TYPE: begin
               if (rd_rsp.done) begin
                  if (rd_rsp.data == esl_pkg::PT_LOAD) begin
                     rd_req_ff.start <= 1'b1;
                     rd_req_ff.addr <= esl_pkg::RD_ADDR_W'(rec_base + AW'(esl_pkg::OFF_FILESZ));
                     state_ff <= S_RD_FSZ;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_RD_FSZ: begin
               if (rd_rsp.done) begin
                  if (rd_rsp.data != 32'd0) begin
                     fsz_ff <= rd_rsp.data;
                     copy_ff <= rd_rsp.data;
                     rd_req_ff.start <= 1'b1;
                     rd_req_ff.addr <= esl_pkg::RD_ADDR_W'(rec_base + AW'(esl_pkg::OFF_OFFSET));
                     state_ff <= S_RD_OFF;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_RD_OFF: begin
               if (rd_rsp.done) begin
                  skip_ff <= rd_rsp.data - pos_ff;
                  rd_req_ff.start <= 1'b1;
                  rd_req_ff.addr <= esl_pkg::RD_ADDR_W'(rec_base + AW'(esl_pkg::OFF_PADDR));
                  state_ff <= S_RD_PADDR;
               end
            end
            S_RD_PADDR: begin
               if (rd_rsp.done) begin
                  dest_ff <= rd_rsp.data;
                  paddr_ff <= rd_rsp.data;
                  rd_req_ff.start <= 1'b1;
                  rd_req_ff.addr <= esl_pkg::RD_ADDR_W'(rec_base + AW'(esl_pkg::OFF_MEMSZ));
                  state_ff <= S_RD_MSZ;
               end
            end
            S_RD_MSZ: begin
               if (rd_rsp.done) begin
                  // The word count is the signed size difference over four, if positive.
                  pend_addr_ff <= paddr_ff + fsz_ff;
                  pend_words_ff <= (mem_diff != 32'd0 && !mem_diff[31]) ?
                                   mem_diff[31:2] : 30'd0;
                  phase_ff <= PH_LOAD;
                  state_ff <= S_RESULT;
               end
            end
            S_ZFETCH: begin
               if (zleft_ff == 32'd0 && zri_ff < zrc_ff) begin
                  dest_ff <= zaddr_ff[zri_ff[ZIW-1:0]];
                  zleft_ff <= {2'd0, zwords_ff[zri_ff[ZIW-1:0]]};
                  zri_ff <= zri_ff + ZCW'(1);
               end else begin
                  state_ff <= S_ZEMIT;
               end
            end
            S_ZEMIT: begin
               if (zleft_ff != 32'd0) begin
                  wv_ff <= 1'b1;
                  ww_ff <= 1'b1;
                  wa_ff <= dest_ff;
                  dest_ff <= dest_ff + 32'd4;
                  zleft_ff <= zleft_ff - 32'd1;
               end else begin
                  phase_ff <= PH_DONE;
               end
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               out_wv_ff <= wv_ff;
               out_ww_ff <= ww_ff;
               out_wa_ff <= wa_ff;
               out_wd_ff <= wd_ff;
               out_done_ff <= (phase_ff == PH_DONE) && !wv_ff;
               out_bad_ff <= (phase_ff == PH_DONE) && !wv_ff && bad_ff;
               out_entry_ff <= ((phase_ff == PH_DONE) && !wv_ff && !bad_ff) ?
                               entry_ff : 32'd0;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, out_entry_ff, out_bad_ff, out_done_ff,
                       out_wd_ff, out_wa_ff, out_wv_ff};
   assign rsp_tuser = out_ww_ff;

   `ESL_ASSERT(a_one_in_flight, req_tvalid && req_tready |-> !rsp_tvalid,
               "input transfer taken while a response is pending")
   `ESL_ASSERT(a_done_no_write, rsp_tvalid && rsp_tdata[65] |-> !rsp_tdata[0],
               "done response carries a write")
   `ESL_ASSERT(a_word_is_write, rsp_tvalid && rsp_tuser |-> rsp_tdata[0],
               "word write flag without a write")
   `ESL_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid,
                      "response pending right after reset")
endmodule

/* sv/esl_word_reader.sv */
// Program header byte store with a little-endian word reader.
module esl_word_reader #(
   parameter int PH_STORE_BYTES = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(PH_STORE_BYTES)-1:0] wr_idx,
   input  logic [7:0]               wr_byte,
   input  esl_pkg::rd_req_type      rd_req,
   output esl_pkg::rd_rsp_type      rd_rsp
);
   localparam int AW = $clog2(PH_STORE_BYTES);

   logic [7:0]    mem [PH_STORE_BYTES];
   logic [7:0]    rd_q_ff;
   logic [AW-1:0] base_ff;
   logic [2:0]    step_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [31:0]   data_ff;
   logic [AW-1:0] rd_addr;

   assign rd_addr = base_ff + AW'(step_ff[1:0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_byte;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // One byte is fetched per cycle; the registered byte shifts into the word in the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (rd_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
            base_ff <= AW'(rd_req.addr);
         end else if (busy_ff) begin
            if (step_ff != 3'd0) begin
               data_ff <= {rd_q_ff, data_ff[31:8]};
            end
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   assign rd_rsp.done = done_ff;
   assign rd_rsp.data = data_ff;
endmodule
